FILE: sv/jdtm_pkg.sv
// Shared types and constants for the joystick differential thrust mixer.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package jdtm_pkg;

  // Field widths
  localparam int SAMPLE_W  = 15;
  localparam int DUTY_W    = 10;
  localparam int DIR_W     = 2;
  // 1023 * |bias| stays below 2^25, so the quotient needs 25 bits
  localparam int NUM_W     = 25;
  localparam int DIV_STEPS = NUM_W;
  localparam int MIX_W     = 13;

  // Scaling constants
  localparam int DEADBAND    = 100;
  localparam int FULL_SCALE  = 1023;
  // Steering beyond twice full scale saturates both motors anyway
  localparam int STEER_LIMIT = 2 * FULL_SCALE + 1;
  localparam int STEER_W     = 11;

  // Register indexes
  localparam logic REG_X_BASELINE = 1'b0;
  localparam logic REG_Y_BASELINE = 1'b1;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

  // One axis in flight through the divider chain
  typedef struct packed {
    logic [SAMPLE_W-1:0] rem;
    logic [NUM_W-1:0]    word;
    logic [SAMPLE_W-1:0] divisor;
    logic                neg;
  } lane_t;

  // One transaction between two cells
  typedef struct packed {
    logic  valid;
    lane_t x;
    lane_t y;
  } stage_t;

endpackage

`default_nettype wire

FILE: sv/jdtm_bias_cell.sv
// Front cell: deadband, bias magnitude, scaling by full scale, divisor pick.
// Depends on jdtm_pkg.
`default_nettype none

module jdtm_bias_cell
  import jdtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                valid,
  input  wire logic [SAMPLE_W-1:0] x_sample,
  input  wire logic [SAMPLE_W-1:0] y_sample,
  input  wire logic [SAMPLE_W-1:0] x_base,
  input  wire logic [SAMPLE_W-1:0] y_base,
  output stage_t                   q
);

  function automatic lane_t make_lane(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] d;
    logic [SAMPLE_W:0]        dneg;
    logic [SAMPLE_W-1:0]      mag;
    logic                     dead;
    lane_t                    r;
    begin
      d    = $signed({1'b0, s}) - $signed({1'b0, b});
      dneg = -d;
      mag  = d[SAMPLE_W] ? dneg[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
      dead = (mag < SAMPLE_W'(DEADBAND));
      r.rem     = '0;
      r.word    = dead ? '0 : NUM_W'(mag) * NUM_W'(FULL_SCALE);
      r.divisor = (b == '0) ? SAMPLE_W'(1) : b;
      r.neg     = d[SAMPLE_W] && !dead;
      return r;
    end
  endfunction

  stage_t d_next;

  always_comb begin
    d_next.valid = valid;
    d_next.x     = make_lane(x_sample, x_base);
    d_next.y     = make_lane(y_sample, y_base);
  end

  // Register the prepared transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= d_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/jdtm_div_cell.sv
// Divider cell: one restoring quotient bit for each axis per cell.
// Depends on jdtm_pkg.
`default_nettype none

module jdtm_div_cell
  import jdtm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire stage_t d,
  output stage_t      q
);

  function automatic lane_t div_step(lane_t a);
    logic [SAMPLE_W:0] trial;
    logic [SAMPLE_W:0] diff;
    logic              ge;
    lane_t             r;
    begin
      trial  = {a.rem, a.word[NUM_W-1]};
      diff   = trial - {1'b0, a.divisor};
      ge     = (trial >= {1'b0, a.divisor});
      r      = a;
      r.rem  = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      r.word = {a.word[NUM_W-2:0], ge};
      return r;
    end
  endfunction

  stage_t d_next;

  always_comb begin
    d_next.valid = d.valid;
    d_next.x     = div_step(d.x);
    d_next.y     = div_step(d.y);
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= d_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/jdtm_mix_cell.sv
// Output cell: clamp, mix thrust and steering, saturate, direction and duty.
// Depends on jdtm_pkg.
`default_nettype none

module jdtm_mix_cell
  import jdtm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire stage_t            d,
  output logic                   out_valid,
  output logic [DIR_W-1:0]       left_dir,
  output logic [DUTY_W-1:0]      left_duty,
  output logic [DIR_W-1:0]       right_dir,
  output logic [DUTY_W-1:0]      right_duty
);

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  function automatic drive_t drive(logic signed [MIX_W-1:0] v);
    logic [MIX_W-1:0] mag;
    drive_t           r;
    begin
      mag = v[MIX_W-1] ? MIX_W'(-v) : MIX_W'(v);
      if (mag > MIX_W'(FULL_SCALE)) begin
        mag = MIX_W'(FULL_SCALE);
      end
      r.duty = mag[DUTY_W-1:0];
      if (mag == '0) begin
        r.dir = DIR_OFF;
      end else if (v[MIX_W-1]) begin
        r.dir = DIR_REV;
      end else begin
        r.dir = DIR_FWD;
      end
      return r;
    end
  endfunction

  logic [DUTY_W-1:0]        tmag;
  logic [STEER_W-1:0]       smag;
  logic signed [MIX_W-1:0]  thrust;
  logic signed [MIX_W-1:0]  steer;
  drive_t                   left_next;
  drive_t                   right_next;

  // Clamp thrust to full scale, steering to the saturating bound
  always_comb begin
    tmag = (d.y.word > NUM_W'(FULL_SCALE)) ? DUTY_W'(FULL_SCALE) : d.y.word[DUTY_W-1:0];
    smag = (d.x.word > NUM_W'(STEER_LIMIT)) ? STEER_W'(STEER_LIMIT) : d.x.word[STEER_W-1:0];
    thrust = d.y.neg ? -$signed(MIX_W'(tmag)) : $signed(MIX_W'(tmag));
    steer  = d.x.neg ? -$signed(MIX_W'(smag)) : $signed(MIX_W'(smag));
    left_next  = drive(thrust - steer);
    right_next = drive(thrust + steer);
  end

  // Hold the result until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_dir   <= left_next.dir;
      left_duty  <= left_next.duty;
      right_dir  <= right_next.dir;
      right_duty <= right_next.duty;
    end
  end

endmodule

`default_nettype wire

FILE: sv/joystick_differential_thrust_mixer_unit.sv
// Top level of the joystick differential thrust mixer: baselines, cell chain.
// Depends on jdtm_pkg, jdtm_bias_cell, jdtm_div_cell and jdtm_mix_cell.
//
//   channel  signals                                   direction
//   input    in_valid, in_stall, x_sample, y_sample    in (stall out)
//   config   cfg_we, cfg_index, cfg_data               in
//   output   out_valid, out_stall, left/right dir/duty out (stall in)
//
// One transaction enters per cycle unless the chain is stalled; the path is the bias cell,
// 25 divider cells (one quotient bit each) and the mix cell, each registered.
// Reset clears all valid flags and sets both baselines to 16384.
// A stalled result freezes the whole chain; in_stall follows it.
`default_nettype none

module joystick_differential_thrust_mixer_unit
  import jdtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] x_sample,
  input  wire logic [SAMPLE_W-1:0] y_sample,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [SAMPLE_W-1:0] cfg_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [DIR_W-1:0]         left_dir,
  output logic [DUTY_W-1:0]        left_duty,
  output logic [DIR_W-1:0]         right_dir,
  output logic [DUTY_W-1:0]        right_duty
);

  logic [SAMPLE_W-1:0] x_base;
  logic [SAMPLE_W-1:0] y_base;
  logic                adv;
  stage_t              pipe [0:DIV_STEPS];

  // Advance the chain unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Write baseline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_base <= SAMPLE_W'(16384);
      y_base <= SAMPLE_W'(16384);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_BASELINE: x_base <= cfg_data;
        REG_Y_BASELINE: y_base <= cfg_data;
        default: ;
      endcase
    end
  end

  jdtm_bias_cell u_bias (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid    (in_valid),
    .x_sample (x_sample),
    .y_sample (y_sample),
    .x_base   (x_base),
    .y_base   (y_base),
    .q        (pipe[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    jdtm_div_cell u_div (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (pipe[i]),
      .q   (pipe[i+1])
    );
  end

  jdtm_mix_cell u_mix (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .d          (pipe[DIV_STEPS]),
    .out_valid  (out_valid),
    .left_dir   (left_dir),
    .left_duty  (left_duty),
    .right_dir  (right_dir),
    .right_duty (right_duty)
  );

endmodule

`default_nettype wire

FILE: sv/jdtm_checker.sv
// Port-level checks for the joystick differential thrust mixer, with bind.
// Depends on jdtm_pkg and joystick_differential_thrust_mixer_unit.
`default_nettype none

module jdtm_checker
  import jdtm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DIR_W-1:0]  left_dir,
  input wire logic [DUTY_W-1:0] left_duty,
  input wire logic [DIR_W-1:0]  right_dir,
  input wire logic [DUTY_W-1:0] right_duty
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(left_dir) && $stable(left_duty)
                                  && $stable(right_dir) && $stable(right_duty)))
    else $error("stalled result changed");

  // Input is held off only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

  // Direction off exactly when duty is zero, and only defined codes
  a_left_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((left_dir == DIR_OFF) == (left_duty == '0)) && (left_dir <= DIR_REV))
    else $error("left direction and duty disagree");

  a_right_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((right_dir == DIR_OFF) == (right_duty == '0)) && (right_dir <= DIR_REV))
    else $error("right direction and duty disagree");

endmodule

bind joystick_differential_thrust_mixer_unit jdtm_checker u_jdtm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .left_dir   (left_dir),
  .left_duty  (left_duty),
  .right_dir  (right_dir),
  .right_duty (right_duty)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the joystick differential thrust mixer unit.
// Depends on jdtm_pkg and joystick_differential_thrust_mixer_unit.
// Predicts each motor command from the stick pair and baselines, then checks it.
module testbench;
  import jdtm_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] xs;
    logic [SAMPLE_W-1:0] ys;
  } stick_pair_t;

  typedef struct {
    logic [DIR_W-1:0]  ldir;
    logic [DUTY_W-1:0] lduty;
    logic [DIR_W-1:0]  rdir;
    logic [DUTY_W-1:0] rduty;
  } motor_cmd_t;

  localparam int MAX_SAMPLE = (1 << SAMPLE_W) - 1;
  localparam int IDLE_PCT   = 27;
  localparam int DRAIN_WAIT = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] x_sample = '0;
  logic [SAMPLE_W-1:0] y_sample = '0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_X_BASELINE;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIR_W-1:0]    left_dir;
  logic [DUTY_W-1:0]   left_duty;
  logic [DIR_W-1:0]    right_dir;
  logic [DUTY_W-1:0]   right_duty;

  // Baselines as the block should hold them
  logic [SAMPLE_W-1:0] x_base = 15'd16384;
  logic [SAMPLE_W-1:0] y_base = 15'd16384;

  stick_pair_t stick_q[$];
  motor_cmd_t  motor_cmd_q[$];

  logic taken = 1'b0;
  int   accepted = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   hold_cnt = 0;
  logic hold_done = 1'b0;
  logic calm;

  joystick_differential_thrust_mixer_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_dir   (left_dir),
    .left_duty  (left_duty),
    .right_dir  (right_dir),
    .right_duty (right_duty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // No idling on either side for a stretch of results
  assign calm = (results_seen >= 400) && (results_seen < 650);

  // Offset from baseline, zero inside the exclusive deadband
  function automatic longint axis_offset(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] b);
    longint sl, bl, d;
    sl = s;
    bl = b;
    d = sl - bl;
    if (d < DEADBAND && d > -DEADBAND) return 0;
    return d;
  endfunction

  // Full-scale term, truncated toward zero; a zero baseline divides by one
  function automatic longint full_scale_term(longint bias, logic [SAMPLE_W-1:0] b);
    longint divisor;
    divisor = (b == '0) ? 1 : b;
    return (FULL_SCALE * bias) / divisor;
  endfunction

  function automatic longint saturate(longint v);
    if (v > FULL_SCALE) return FULL_SCALE;
    if (v < -FULL_SCALE) return -FULL_SCALE;
    return v;
  endfunction

  function automatic logic [DIR_W+DUTY_W-1:0] motor_code(longint power);
    if (power > 0) return {DIR_FWD, DUTY_W'(power)};
    if (power < 0) return {DIR_REV, DUTY_W'(-power)};
    return {DIR_OFF, {DUTY_W{1'b0}}};
  endfunction

  function automatic motor_cmd_t mix_motors(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                                            logic [SAMPLE_W-1:0] xb, logic [SAMPLE_W-1:0] yb);
    longint thrust, steer;
    motor_cmd_t cmd;
    thrust = saturate(full_scale_term(axis_offset(ys, yb), yb));
    steer  = full_scale_term(axis_offset(xs, xb), xb);
    {cmd.ldir, cmd.lduty} = motor_code(saturate(thrust - steer));
    {cmd.rdir, cmd.rduty} = motor_code(saturate(thrust + steer));
    return cmd;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Drive stick pairs: hold a stalled transaction, otherwise advance or idle
  always @(negedge clk) begin
    stick_pair_t item;
    if (!rst && !(in_valid && !taken)) begin
      if (stick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        item = stick_q.pop_front();
        x_sample <= item.xs;
        y_sample <= item.ys;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: one long hold-off, otherwise random
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && results_seen >= 200) begin
      hold_done <= 1'b1;
      hold_cnt <= 119;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Record accepted pairs and check motor commands
  always @(posedge clk) begin
    motor_cmd_t want;
    taken <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        motor_cmd_q.push_back(mix_motors(x_sample, y_sample, x_base, y_base));
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (motor_cmd_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d %0d/%0d", $time,
                   left_dir, left_duty, right_dir, right_duty);
        end else begin
          want = motor_cmd_q.pop_front();
          check_field("left_dir", want.ldir, left_dir);
          check_field("left_duty", want.lduty, left_duty);
          check_field("right_dir", want.rdir, right_dir);
          check_field("right_duty", want.rduty, right_duty);
        end
        results_seen++;
      end
    end
  end

  task automatic queue_pair(int x, int y);
    stick_pair_t p;
    if (x >= 0 && x <= MAX_SAMPLE && y >= 0 && y <= MAX_SAMPLE) begin
      p.xs = SAMPLE_W'(x);
      p.ys = SAMPLE_W'(y);
      stick_q.push_back(p);
    end
  endtask

  // Samples on both sides of each deadband edge
  task automatic queue_deadband_edges(int xb, int yb);
    queue_pair(xb + DEADBAND - 1, yb);
    queue_pair(xb - DEADBAND + 1, yb);
    queue_pair(xb + DEADBAND, yb);
    queue_pair(xb - DEADBAND, yb);
    queue_pair(xb, yb + DEADBAND - 1);
    queue_pair(xb, yb - DEADBAND + 1);
    queue_pair(xb, yb + DEADBAND);
    queue_pair(xb, yb - DEADBAND);
  endtask

  function automatic int near_value(int center, int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > MAX_SAMPLE) v = MAX_SAMPLE;
    return v;
  endfunction

  function automatic int edge_value(int center);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return MAX_SAMPLE;
      2: return near_value(center + DEADBAND, 0);
      3: return near_value(center - DEADBAND, 0);
      4: return near_value(center + DEADBAND - 1, 0);
      default: return near_value(center - DEADBAND + 1, 0);
    endcase
  endfunction

  // Full-range samples, plenty near the baselines and edges
  task automatic queue_random(int count);
    int xb, yb, mode;
    xb = x_base;
    yb = y_base;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) queue_pair($urandom_range(0, MAX_SAMPLE), $urandom_range(0, MAX_SAMPLE));
      else if (mode < 7) queue_pair(near_value(xb, 160), near_value(yb, 160));
      else if (mode == 7) queue_pair(edge_value(xb), edge_value(yb));
      else if (mode == 8) queue_pair(near_value(xb, 160), $urandom_range(0, MAX_SAMPLE));
      else queue_pair($urandom_range(0, MAX_SAMPLE), near_value(yb, 160));
    end
  endtask

  task automatic cfg_write(logic idx, logic [SAMPLE_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_X_BASELINE) x_base = value;
    else y_base = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_baselines(int xb, int yb);
    cfg_write(REG_X_BASELINE, SAMPLE_W'(xb));
    cfg_write(REG_Y_BASELINE, SAMPLE_W'(yb));
  endtask

  // Wait until every queued pair is accepted and every result has come
  task automatic wait_drained;
    do @(posedge clk);
    while (stick_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic int random_baseline();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 400);
      1: return near_value(16384, 2000);
      default: return $urandom_range(1, MAX_SAMPLE);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset baselines: stick corners, center and deadband edges
    queue_pair(16384, 16384);
    queue_pair(0, 16384);
    queue_pair(MAX_SAMPLE, 16384);
    queue_pair(16384, 0);
    queue_pair(16384, MAX_SAMPLE);
    queue_pair(0, 0);
    queue_pair(MAX_SAMPLE, MAX_SAMPLE);
    queue_pair(0, MAX_SAMPLE);
    queue_pair(MAX_SAMPLE, 0);
    queue_deadband_edges(16384, 16384);
    queue_random(120);
    wait_drained();

    // Smallest nonzero and largest baselines
    set_baselines(1, MAX_SAMPLE);
    queue_pair(0, 0);
    queue_pair(MAX_SAMPLE, MAX_SAMPLE);
    queue_random(120);
    wait_drained();

    set_baselines(MAX_SAMPLE, 1);
    queue_pair(0, 0);
    queue_pair(MAX_SAMPLE, MAX_SAMPLE);
    queue_random(120);
    wait_drained();

    // Zero baselines: deadband against zero, division by one
    set_baselines(0, 0);
    queue_deadband_edges(0, 0);
    queue_pair(MAX_SAMPLE, MAX_SAMPLE);
    queue_random(120);
    wait_drained();

    repeat (3) begin
      set_baselines(random_baseline(), random_baseline());
      queue_random(140);
      wait_drained();
    end

    // Back to the rest position
    set_baselines(16384, 16384);
    queue_random(130);
    wait_drained();

    $display("Checked %0d motor commands from %0d stick pairs across eight baseline settings,",
             results_seen, accepted);
    $display("including zero and extreme baselines, deadband edges and a long output hold-off.");
    if (errors == 0) begin
      $display("** joystick_differential_thrust_mixer_unit: PASSED **");
    end else begin
      $display("** joystick_differential_thrust_mixer_unit: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5000000;
    $display("%0t: timeout with %0d results outstanding", $time, motor_cmd_q.size());
    $display("** joystick_differential_thrust_mixer_unit: FAILED **");
    $finish;
  end

endmodule
